### rtl/core/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");

`endif

### rtl/core/tpmpr_pkg.sv
`default_nettype none
package tpmpr_pkg;
  localparam int unsigned HIST_DEPTH_DEF = 512;
  localparam logic [7:0]  SKIP_RESET     = 8'd5;
  localparam logic [1:0]  OP_PUSH  = 2'd0;
  localparam logic [1:0]  OP_START = 2'd1;
  localparam logic [1:0]  OP_POINT = 2'd2;
  localparam logic        CFG_USE_HIST = 1'b0;
  localparam logic        CFG_SKIP     = 1'b1;
  localparam int unsigned ENTRY_W = 32 + 96 + 64;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -38'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

### rtl/core/tpmpr_ram.sv
`default_nettype none
module tpmpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/core/timed_pose_match_point_register.sv
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | opcode, time, position, trig, last
// out     | out | out_valid/out_ready | x, y, z, pose time, last
// cfg     | in  | cfg_we              | cfg_index, cfg_data
// pose push: written in S_IDLE, then through S_WAIT. dropped scan start, stray point, unused opcode: stay in S_IDLE.
// scan point: through one shared 35x17 multiplier in S_MUL, then out in S_EMIT.
// scan start: straight to the load with the match pointer already newest, else a search
// through S_CMP and S_STEP that stops on an entry not older than the start or on the newest.
// synchronous active-low reset, no memory clearing pass.
// a finished point waits in the emit state while the output register is still full and out_ready is low.
`default_nettype none
module timed_pose_match_point_register
  import tpmpr_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HIST_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [31:0]        in_time_stamp,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [15:0] in_sin_roll,
  input  wire logic signed [15:0] in_cos_roll,
  input  wire logic signed [15:0] in_sin_pitch,
  input  wire logic signed [15:0] in_cos_pitch,
  input  wire logic               in_last_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_out_x,
  output logic signed [31:0]      out_out_y,
  output logic signed [31:0]      out_out_z,
  output logic [31:0]             out_pose_time,
  output logic                    out_last_out,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [7:0]         cfg_data
);
  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WAIT = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_LAT  = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;
  localparam logic [2:0] S_STEP = 3'd7;

  logic [2:0] state_r;
  logic use_hist_r;
  logic [7:0] skip_r, init_cnt_r;
  logic init_r, seen_r, scan_r;
  logic [AW-1:0] wptr_r, mptr_r, rd_addr;
  logic [AW-1:0] newest, mnext;
  logic [2:0] step_r;

  logic [31:0] t_r, px_r, py_r, pz_r;
  logic last_r;
  logic signed [31:0] selx_r, sely_r, selz_r;
  logic [31:0] sel_time_r;
  logic signed [15:0] sr_r, cr_r, sp_r, cp_r;
  logic signed [49:0] acc_r;
  logic signed [34:0] y1_r, z1_r;
  logic signed [35:0] x2_r, z2_r;

  logic ram_we;
  logic [ENTRY_W-1:0] ram_wd, ram_rd;
  logic hit;

  assign newest = (wptr_r == '0) ? LAST_IDX : wptr_r - AW'(1);
  assign mnext  = (mptr_r == LAST_IDX) ? '0 : mptr_r + AW'(1);
  assign ram_we = in_valid && in_ready && in_opcode == OP_PUSH;
  assign ram_wd = {in_time_stamp, in_pos_x, in_pos_y, in_pos_z,
                   in_sin_roll, in_cos_roll, in_sin_pitch, in_cos_pitch};
  assign hit = ram_rd[ENTRY_W-1 -: 32] < t_r;

  tpmpr_ram #(.WIDTH(ENTRY_W), .DEPTH(HISTORY_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(wptr_r), .wdata(ram_wd),
    .raddr(rd_addr), .rdata(ram_rd)
  );

  // shared multiplier: 35-bit operand by 17-bit coefficient
  logic signed [34:0] m_a;
  logic signed [16:0] m_b;
  logic signed [49:0] m_p;
  logic signed [49:0] sum;
  logic signed [35:0] rnd;
  always_comb begin
    unique case (step_r)
      3'd0: begin m_a = 35'(signed'(py_r)); m_b = 17'(cr_r); end
      3'd1: begin m_a = 35'(signed'(pz_r)); m_b = -17'(sr_r); end
      3'd2: begin m_a = 35'(signed'(py_r)); m_b = 17'(sr_r); end
      3'd3: begin m_a = 35'(signed'(pz_r)); m_b = 17'(cr_r); end
      3'd4: begin m_a = 35'(signed'(px_r)); m_b = 17'(cp_r); end
      3'd5: begin m_a = z1_r; m_b = 17'(sp_r); end
      3'd6: begin m_a = z1_r; m_b = 17'(cp_r); end
      3'd7: begin m_a = 35'(signed'(px_r)); m_b = -17'(sp_r); end
    endcase
  end
  assign m_p = 50'(m_a * m_b);
  assign sum = acc_r + m_p + 50'sd8192;
  assign rnd = 36'(sum >>> 14);

  logic do_emit;
  assign do_emit = (state_r == S_EMIT) && (!out_valid || out_ready);
  assign in_ready = (state_r == S_IDLE);
  assign rd_addr = (state_r == S_LOAD) ? (use_hist_r ? mptr_r : newest) : mnext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; use_hist_r <= 1'b0; skip_r <= SKIP_RESET;
      init_cnt_r <= '0; init_r <= 1'b0; seen_r <= 1'b0; scan_r <= 1'b0;
      wptr_r <= '0; mptr_r <= '0; out_valid <= 1'b0; step_r <= '0;
      selx_r <= '0; sely_r <= '0; selz_r <= '0; sel_time_r <= '0;
      sr_r <= '0; cr_r <= '0; sp_r <= '0; cp_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_USE_HIST: use_hist_r <= cfg_data[0];
          CFG_SKIP:     skip_r <= cfg_data;
          default: ;
        endcase
      end
      if (do_emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            t_r <= in_time_stamp; px_r <= in_pos_x; py_r <= in_pos_y;
            pz_r <= in_pos_z; last_r <= in_last_in;
            unique case (in_opcode)
              OP_PUSH: begin
                wptr_r <= (wptr_r == LAST_IDX) ? '0 : wptr_r + AW'(1);
                seen_r <= 1'b1;
                state_r <= S_WAIT;
              end
              OP_START: begin
                if (!init_r) begin
                  if (9'(init_cnt_r) + 9'd1 > 9'(skip_r)) init_r <= 1'b1;
                  if (init_cnt_r != 8'hFF) init_cnt_r <= init_cnt_r + 8'd1;
                  scan_r <= 1'b0;
                end else if (!seen_r) begin
                  scan_r <= 1'b0;
                end else if (mptr_r == newest) begin
                  state_r <= S_LOAD;
                end else begin
                  state_r <= S_CMP;
                end
              end
              OP_POINT: begin
                if (scan_r) begin
                  step_r <= '0; acc_r <= '0; state_r <= S_MUL;
                end
              end
              default: ;
            endcase
          end
        end
        S_WAIT: state_r <= S_IDLE;
        S_CMP: begin
          if (hit) begin
            mptr_r <= mnext;
            state_r <= (mnext == newest) ? S_LOAD : S_STEP;
          end else begin
            state_r <= S_LOAD;
          end
        end
        // wait state for the read of the next entry
        S_STEP: state_r <= S_CMP;
        S_LOAD: state_r <= S_LAT;
        S_LAT: begin
          sel_time_r <= ram_rd[191:160];
          selx_r <= ram_rd[159:128]; sely_r <= ram_rd[127:96];
          selz_r <= ram_rd[95:64];
          sr_r <= ram_rd[63:48]; cr_r <= ram_rd[47:32];
          sp_r <= ram_rd[31:16]; cp_r <= ram_rd[15:0];
          scan_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_MUL: begin
          step_r <= step_r + 3'd1;
          if (step_r[0] == 1'b0) begin
            acc_r <= m_p;
          end else begin
            acc_r <= '0;
            unique case (step_r)
              3'd1: y1_r <= 35'(rnd);
              3'd3: z1_r <= 35'(rnd);
              3'd5: x2_r <= rnd;
              3'd7: begin
                z2_r <= rnd;
                state_r <= S_EMIT;
              end
              default: ;
            endcase
          end
        end
        S_EMIT: begin
          if (do_emit) begin
            out_out_x <= sat32(38'(x2_r) + 38'(selx_r));
            out_out_y <= sat32(38'(y1_r) + 38'(sely_r));
            out_out_z <= sat32(38'(z2_r) + 38'(selz_r));
            out_pose_time <= sel_time_r;
            out_last_out <= last_r;
            if (last_r) scan_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/core/tpmpr_checker.sv
`default_nettype none
`include "assert_macros.svh"
module tpmpr_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last_out
);
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_last_hold, clk, rst_n, out_valid && !out_ready, $stable(out_last_out))
  `ASSERT_IMPL(a_no_x_valid, clk, rst_n, 1'b1, !$isunknown(out_valid))
  `ASSERT_IMPL(a_no_x_ready, clk, rst_n, in_valid, !$isunknown(in_ready))
endmodule
bind timed_pose_match_point_register tpmpr_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_last_out(out_last_out)
);
`default_nettype wire
